FILE: src/packet_capture_ring_stats_top_defines.svh
// Assertion macros shared by the packet capture ring modules.
// Expects clk_i and rst_ni in the scope of every use.
`ifndef PACKET_CAPTURE_RING_STATS_TOP_DEFINES_SVH
`define PACKET_CAPTURE_RING_STATS_TOP_DEFINES_SVH

// Check a condition at every clock edge outside reset.
`define PCRS_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// Check a consequence in the same cycle as its cause.
`define PCRS_ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Check a consequence in the cycle after its cause.
`define PCRS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/pcrs_pkg.sv
// Shared widths, codes, reset values and types of the packet capture ring.
// No dependencies; used by pcrs_mod and packet_capture_ring_stats_top.
package pcrs_pkg;

  // Ring geometry
  localparam int OFFSET_BITS = 27;
  localparam int PTR_W       = OFFSET_BITS;
  localparam int NUM_W       = OFFSET_BITS + 1;
  localparam logic [NUM_W-1:0] CAP_MAX = NUM_W'(1) << OFFSET_BITS;

  // Field widths
  localparam int KIND_W    = 2;
  localparam int PORT_W    = 4;
  localparam int BYTES_W   = 14;
  localparam int STAMP_W   = 32;
  localparam int SEQ_W     = 32;
  localparam int STATUS_W  = 3;
  localparam int CHUNK_W   = 28;
  localparam int NUMBER_W  = 46;
  localparam int COUNT_W   = 48;
  localparam int CFG_W     = 28;
  localparam int CFG_IDX_W = 3;
  localparam int LEN_W     = BYTES_W + 1;

  localparam int S_TDATA_W = 88;
  localparam int M_TDATA_W = 400;

  // Module parameter defaults
  localparam int DEF_PORT_COUNT = 12;
  localparam int DEF_MAX_PACKET = 10000;

  // Item kinds
  localparam logic [KIND_W-1:0] KIND_PACKET = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DRAIN  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd2;

  // Result status codes
  localparam logic [STATUS_W-1:0] STAT_STORED  = 3'd0;
  localparam logic [STATUS_W-1:0] STAT_DROPPED = 3'd1;
  localparam logic [STATUS_W-1:0] STAT_BAD_LEN = 3'd2;
  localparam logic [STATUS_W-1:0] STAT_DRAINED = 3'd3;
  localparam logic [STATUS_W-1:0] STAT_CLEARED = 3'd4;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_REQ_LEN   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RING_SIZE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_CHUNK = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CHECK_EN  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PREFIX_EN = 3'd4;

  // Register reset values
  localparam logic [BYTES_W-1:0] RST_REQ_LEN   = '0;
  localparam logic [CFG_W-1:0]   RST_RING_SIZE = 28'd104857600;
  localparam logic [CFG_W-1:0]   RST_MAX_CHUNK = 28'd1048576;

  localparam logic [LEN_W-1:0] PREFIX_BYTES = 15'd2;

  // Packet number arithmetic: ticks = stamp * 1e6 * rate, rounded / 1024, plus sequence, then / 16
  localparam int MUL_W      = 28;
  localparam int SCALE      = 1000000;
  localparam int RATE_BASE  = 160;
  localparam int RATE_STEP  = 40;
  localparam logic [MUL_W-1:0] RATE_LO = MUL_W'(SCALE * RATE_BASE);
  localparam logic [MUL_W-1:0] RATE_HI = MUL_W'(SCALE * (RATE_BASE + RATE_STEP));
  localparam int ROUND_BIAS = 512;
  localparam int T_SHIFT    = 10;
  localparam int N_SHIFT    = 4;

  typedef struct packed {
    logic [NUMBER_W-1:0] first;
    logic [COUNT_W-1:0]  seen;
    logic [COUNT_W-1:0]  dropped;
    logic [COUNT_W-1:0]  good;
    logic [COUNT_W-1:0]  stored;
  } stats_t;

  localparam stats_t STATS_RESET = '{first: '1, seen: '0, dropped: '0, good: '0, stored: '0};

  // Remainder unit request and response
  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] num;
    logic [NUM_W-1:0] den;
  } mod_req_t;

  typedef struct packed {
    logic             done;
    logic [PTR_W-1:0] rem;
  } mod_rsp_t;

endpackage

FILE: src/pcrs_mod.sv
// Pointer wrap unit: remainder of a ring sum by the ring capacity.
// A single subtraction gives the remainder when the sum is below twice the capacity, else one bit a cycle.
// Depends on pcrs_pkg and packet_capture_ring_stats_top_defines.svh.
`include "packet_capture_ring_stats_top_defines.svh"

module pcrs_mod import pcrs_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  mod_req_t req_i,
  output mod_rsp_t rsp_o
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic             busy_q, done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [NUM_W-1:0] num_q, den_q;
  logic [PTR_W-1:0] rem_q;

  logic [NUM_W-1:0] diff, step_val, step_diff;
  logic             fit_low, fit_once, step_ge;

  always_comb begin
    diff      = req_i.num - req_i.den;
    fit_low   = req_i.num < req_i.den;
    fit_once  = diff < req_i.den;
    step_val  = {rem_q, num_q[NUM_W-1]};
    step_ge   = step_val >= den_q;
    step_diff = step_val - den_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        if (fit_low || fit_once) begin
          done_q <= 1'b1;
        end else begin
          busy_q <= 1'b1;
          cnt_q  <= '0;
        end
      end else if (busy_q) begin
        cnt_q <= cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(NUM_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Restoring remainder, numerator bits in from the top
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      den_q <= req_i.den;
      num_q <= req_i.num;
      if (fit_low) begin
        rem_q <= req_i.num[PTR_W-1:0];
      end else if (fit_once) begin
        rem_q <= diff[PTR_W-1:0];
      end else begin
        rem_q <= '0;
      end
    end else if (busy_q) begin
      num_q <= {num_q[NUM_W-2:0], 1'b0};
      rem_q <= step_ge ? step_diff[PTR_W-1:0] : step_val[PTR_W-1:0];
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.rem  = rem_q;

  `PCRS_ASSERT_IMPLIES(a_rem_below_cap, done_q, {1'b0, rem_q} < den_q, "remainder not below capacity")
  `PCRS_ASSERT_IMPLIES(a_no_start_busy, req_i.start, !busy_q, "start while iterating")
  `PCRS_ASSERT_IMPLIES(a_cnt_range, busy_q, cnt_q < CNT_W'(NUM_W), "iteration count overrun")

endmodule

FILE: src/packet_capture_ring_stats_top.sv
// Packet capture ring admission and per-port statistics, top level.
// Depends on pcrs_pkg, pcrs_mod and packet_capture_ring_stats_top_defines.svh.
//
//  channel   dir  handshake                  payload
//  s_axis    in   s_axis_tvalid/tready       tuser: kind; tdata: packet header fields
//  m_axis    out  m_axis_tvalid/tready       tuser: status; tdata: offsets and statistics
//  cfg       in   cfg_we_i (no wait)         cfg_index_i, cfg_data_i
//
// An item passes the steps accept, memory read and multiply, round and wrap, and write back;
// when the advanced pointer reaches twice the ring capacity, the bit-serial wrap unit
// extends the round and wrap step. A new item is accepted only once the last is written back.
// Reset clears pointers, occupancy, peak and all per-port valid bits at once; no sweep.
// A result beat waiting on m_axis does not block the next accept; write back holds
// until the output register is free.
`include "packet_capture_ring_stats_top_defines.svh"

module packet_capture_ring_stats_top import pcrs_pkg::*; #(
  parameter int PORT_COUNT = DEF_PORT_COUNT,
  parameter int MAX_PACKET = DEF_MAX_PACKET
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // port [3:0], packet_bytes [17:4], stamp_seconds [49:18], block_sequence [81:50],
  // error_flag [82], clock_200 [83], zero [87:84]
  input  logic [S_TDATA_W-1:0] s_axis_tdata,
  // kind [1:0]
  input  logic [KIND_W-1:0]    s_axis_tuser,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // ring_offset [26:0], chunk_length [54:27], packet_number [100:55], first_number [146:101],
  // seen_count [194:147], dropped_count [242:195], good_count [290:243],
  // stored_bytes [338:291], fill_level [365:339], peak_fill [392:366], zero [399:393]
  output logic [M_TDATA_W-1:0] m_axis_tdata,
  // status [2:0]
  output logic [STATUS_W-1:0]  m_axis_tuser,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_data_i
);

  localparam int PIDX_W = (PORT_COUNT > 1) ? $clog2(PORT_COUNT) : 1;
  localparam int PEXT_W = 7;
  localparam int PKT_W  = 17;
  localparam int PROD_W = STAMP_W + MUL_W + 1;
  localparam int T_W    = PROD_W - T_SHIFT;
  localparam int SUM_W  = T_W + 1;

  // Sequencer codes
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RD   = 2'd1;
  localparam logic [1:0] ST_MOD  = 2'd2;
  localparam logic [1:0] ST_WB   = 2'd3;

  logic [1:0] state_q, state_d;

  // Configuration registers
  logic [BYTES_W-1:0] req_len_q;
  logic [CFG_W-1:0]   ring_size_q, max_chunk_q;
  logic               check_en_q, prefix_en_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_len_q   <= RST_REQ_LEN;
      ring_size_q <= RST_RING_SIZE;
      max_chunk_q <= RST_MAX_CHUNK;
      check_en_q  <= 1'b0;
      prefix_en_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_REQ_LEN:   req_len_q   <= cfg_data_i[BYTES_W-1:0];
        REG_RING_SIZE: ring_size_q <= cfg_data_i;
        REG_MAX_CHUNK: max_chunk_q <= cfg_data_i;
        REG_CHECK_EN:  check_en_q  <= cfg_data_i[0];
        REG_PREFIX_EN: prefix_en_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Input beat unpack
  logic                     s_accept;
  logic [PORT_W-1:0]        in_port;
  logic [PEXT_W-1:0]        in_port_ext;
  logic [PIDX_W-1:0]        in_idx;
  logic                     in_port_ok;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign s_accept      = s_axis_tvalid && s_axis_tready;
  assign in_port       = s_axis_tdata[3:0];
  assign in_port_ext   = PEXT_W'(in_port);
  assign in_idx        = in_port_ext[PIDX_W-1:0];
  assign in_port_ok    = in_port_ext < PEXT_W'(PORT_COUNT);

  // Held item (payload, no reset)
  logic [KIND_W-1:0]         kind_q;
  logic [PORT_W-1:0]         port_q;
  logic [BYTES_W-1:0]        bytes_q;
  logic signed [STAMP_W-1:0] ts_q;
  logic signed [SEQ_W-1:0]   seq_q;
  logic                      err_q, clk200_q;

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      kind_q   <= s_axis_tuser;
      port_q   <= in_port;
      bytes_q  <= s_axis_tdata[17:4];
      ts_q     <= s_axis_tdata[49:18];
      seq_q    <= s_axis_tdata[81:50];
      err_q    <= s_axis_tdata[82];
      clk200_q <= s_axis_tdata[83];
    end
  end

  // Ring state
  logic [PTR_W-1:0] wp_q, rp_q, occ_q, peak_q;
  logic [PTR_W-1:0] occ_d, peak_d;

  // Per-port statistics memory with valid bits; an entry not valid reads as reset stats
  stats_t                stat_mem [PORT_COUNT];
  stats_t                rd_q;
  logic                  rd_valid_q;
  logic [PORT_COUNT-1:0] valid_q;
  logic                  mem_we, wb_fire, is_clear;
  logic [PEXT_W-1:0]     port_ext;
  logic [PIDX_W-1:0]     port_idx;
  logic                  port_ok;
  stats_t                stats_cur, stats_new;

  assign port_ext = PEXT_W'(port_q);
  assign port_idx = port_ext[PIDX_W-1:0];
  assign port_ok  = port_ext < PEXT_W'(PORT_COUNT);

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      rd_q <= stat_mem[in_idx];
    end
    if (mem_we) begin
      stat_mem[port_idx] <= stats_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (s_accept) begin
        rd_valid_q <= in_port_ok && valid_q[in_idx];
      end
      if (wb_fire && is_clear) begin
        valid_q <= '0;
      end else if (mem_we) begin
        valid_q[port_idx] <= 1'b1;
      end
    end
  end

  // Admission decisions, all from held item, configuration and ring state
  logic [NUM_W-1:0] cap;
  logic [LEN_W-1:0] len;
  logic             bytes_bad, pkt_ok, do_store, is_drain, is_packet;
  logic [PTR_W-1:0] drain_n;
  logic [NUM_W-1:0] occ_plus_len;

  always_comb begin
    if (ring_size_q == '0) begin
      cap = NUM_W'(1);
    end else if (NUM_W'(ring_size_q) > CAP_MAX) begin
      cap = CAP_MAX;
    end else begin
      cap = NUM_W'(ring_size_q);
    end
    is_packet    = (kind_q == KIND_PACKET);
    is_drain     = (kind_q == KIND_DRAIN);
    is_clear     = (kind_q == KIND_CLEAR);
    len          = LEN_W'(bytes_q) + (prefix_en_q ? PREFIX_BYTES : LEN_W'(0));
    bytes_bad    = (bytes_q == '0) || (PKT_W'(bytes_q) >= PKT_W'(MAX_PACKET)) ||
                   ((req_len_q != '0) && (bytes_q != req_len_q));
    pkt_ok       = is_packet && port_ok && !bytes_bad;
    occ_plus_len = NUM_W'(occ_q) + NUM_W'(len);
    do_store     = pkt_ok && (occ_plus_len < cap);
    drain_n      = (NUM_W'(occ_q) < NUM_W'(max_chunk_q)) ? occ_q : max_chunk_q[PTR_W-1:0];
  end

  // Pointer wrap unit
  mod_req_t mod_req;
  mod_rsp_t mod_rsp;
  logic     need_mod_q;

  always_comb begin
    mod_req.start = (state_q == ST_RD) && (do_store || is_drain);
    mod_req.num   = is_drain ? (NUM_W'(rp_q) + NUM_W'(drain_n))
                             : (NUM_W'(wp_q) + NUM_W'(len));
    mod_req.den   = cap;
  end

  pcrs_mod u_mod (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mod_req),
    .rsp_o  (mod_rsp)
  );

  // Packet number: multiply, then round and truncate toward zero
  logic        [MUL_W-1:0]  rate_mul;
  logic signed [MUL_W:0]    rate_s;
  logic signed [PROD_W-1:0] prod_d, prod_q, t_bias, t_adj;
  logic signed [T_W-1:0]    t_q;
  logic signed [SUM_W-1:0]  n_sum, n_adj;
  logic [NUMBER_W-1:0]      number;

  always_comb begin
    rate_mul = clk200_q ? RATE_HI : RATE_LO;
    rate_s   = $signed({1'b0, rate_mul});
    prod_d   = ts_q * rate_s;
    t_bias   = prod_q + PROD_W'(ROUND_BIAS);
    t_adj    = t_bias + (t_bias[PROD_W-1] ? PROD_W'((1 << T_SHIFT) - 1) : PROD_W'(0));
    n_sum    = {t_q[T_W-1], t_q} + SUM_W'(seq_q);
    n_adj    = n_sum + (n_sum[SUM_W-1] ? SUM_W'((1 << N_SHIFT) - 1) : SUM_W'(0));
    number   = n_adj[N_SHIFT +: NUMBER_W];
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_RD) begin
      prod_q <= prod_d;
    end
    if (state_q == ST_MOD) begin
      t_q <= t_adj[T_SHIFT +: T_W];
    end
  end

  // Statistics update
  always_comb begin
    stats_cur = rd_valid_q ? rd_q : STATS_RESET;
    stats_new = stats_cur;
    if (pkt_ok) begin
      stats_new.seen = stats_cur.seen + COUNT_W'(1);
      if (check_en_q) begin
        if (stats_cur.first == '1) begin
          stats_new.first = number;
        end
        if (!err_q && (ts_q != '1)) begin
          stats_new.good = stats_cur.good + COUNT_W'(1);
        end
      end
      if (do_store) begin
        stats_new.stored = stats_cur.stored + COUNT_W'(len);
      end else begin
        stats_new.dropped = stats_cur.dropped + COUNT_W'(1);
      end
    end
    if (is_clear) begin
      stats_new = STATS_RESET;
    end
  end

  assign wb_fire = (state_q == ST_WB) && (!m_axis_tvalid || m_axis_tready);
  assign mem_we  = wb_fire && pkt_ok;

  // Occupancy after this item
  always_comb begin
    occ_d  = occ_q;
    peak_d = peak_q;
    if (do_store) begin
      occ_d = occ_plus_len[PTR_W-1:0];
      if (occ_d > peak_q) begin
        peak_d = occ_d;
      end
    end else if (is_drain) begin
      occ_d = occ_q - drain_n;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q   <= '0;
      rp_q   <= '0;
      occ_q  <= '0;
      peak_q <= '0;
    end else if (wb_fire) begin
      occ_q  <= occ_d;
      peak_q <= peak_d;
      if (do_store) begin
        wp_q <= mod_rsp.rem;
      end
      if (is_drain) begin
        rp_q <= mod_rsp.rem;
      end
    end
  end

  // Sequencer: kind 3 is swallowed at accept
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (s_accept && (s_axis_tuser == KIND_PACKET || s_axis_tuser == KIND_DRAIN ||
                         s_axis_tuser == KIND_CLEAR)) begin
          state_d = ST_RD;
        end
      end
      ST_RD:   state_d = ST_MOD;
      ST_MOD: begin
        if (!need_mod_q || mod_rsp.done) begin
          state_d = ST_WB;
        end
      end
      ST_WB: begin
        if (wb_fire) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      need_mod_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_RD) begin
        need_mod_q <= mod_req.start;
      end
    end
  end

  // Result beat
  logic [STATUS_W-1:0] res_status;
  logic [PTR_W-1:0]    res_offset;
  logic [CHUNK_W-1:0]  res_chunk;
  logic [NUMBER_W-1:0] res_number;
  stats_t              res_stats;
  logic                m_valid_q;
  logic [M_TDATA_W-1:0] m_data_q;
  logic [STATUS_W-1:0] m_user_q;

  always_comb begin
    res_status = STAT_CLEARED;
    res_offset = '0;
    res_chunk  = '0;
    res_number = '0;
    if (is_packet) begin
      if (!pkt_ok) begin
        res_status = STAT_BAD_LEN;
      end else begin
        res_chunk  = CHUNK_W'(len);
        res_number = check_en_q ? number : '0;
        if (do_store) begin
          res_status = STAT_STORED;
          res_offset = wp_q;
        end else begin
          res_status = STAT_DROPPED;
        end
      end
    end else if (is_drain) begin
      res_status = STAT_DRAINED;
      res_offset = rp_q;
      res_chunk  = CHUNK_W'(drain_n);
    end
    res_stats = port_ok ? stats_new : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (wb_fire) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wb_fire) begin
      m_user_q <= res_status;
      m_data_q <= M_TDATA_W'({peak_d, occ_d, res_stats.stored, res_stats.good,
                              res_stats.dropped, res_stats.seen, res_stats.first,
                              res_number, res_chunk, res_offset});
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

  `PCRS_ASSERT_ALWAYS(a_occ_le_peak, occ_q <= peak_q, "occupancy above peak")
  `PCRS_ASSERT_IMPLIES(a_wrap_in_wait, mod_rsp.done, state_q == ST_MOD, "wrap result outside wait")
  `PCRS_ASSERT_NEXT(a_wb_to_idle, wb_fire, state_q == ST_IDLE, "write back did not retire")
  `PCRS_ASSERT_IMPLIES(a_beat_from_wb, $rose(m_axis_tvalid), $past(state_q == ST_WB),
    "result beat without write back")

endmodule
